// ===== rtl/core/assert_macros.svh =====
// Assertion helpers for the RTL files, included by atb_dp.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Property checked at every clock edge, reset included.
`define ASSERT_RESET(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("reset assertion failed");

`endif

// ===== rtl/core/atb_pkg.sv =====
package atb_pkg;

   localparam int MAX_ENTRIES_DEF = 64;
   localparam int WEIGHT_BITS     = 32;
   localparam int INDEX_BITS      = 16;
   localparam int THR_FRAC_BITS   = 16;

   localparam logic [31:0] WEIGHT_MASK = 32'((64'd1 << WEIGHT_BITS) - 64'd1);
   localparam logic [15:0] INDEX_MASK  = 16'((64'd1 << INDEX_BITS) - 64'd1);
   localparam logic [16:0] THR_ONE     = 17'h10000;

   typedef struct packed {
      logic [31:0] weight;
      logic [15:0] light_index;
      logic        last_weight;
   } atb_req_type;

   typedef struct packed {
      logic [16:0] threshold;
      logic [15:0] alias_index;
      logic [15:0] own_index;
      logic [31:0] entry_weight;
      logic        last_entry;
   } atb_rsp_type;

   typedef struct packed {
      logic load;
      logic crd;
      logic cmul;
      logic cwr;
      logic qrd;
      logic lrd;
      logic hrd;
      logic cap;
      logic emit;
   } atb_cmd_type;

   typedef struct packed {
      logic i_last;
      logic pair;
      logic div_busy;
      logic out_free;
   } atb_stat_type;

endpackage

// ===== rtl/core/atb_div.sv =====
module atb_div import atb_pkg::*; #(
   parameter int WW = 38
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [WW-1:0]            dividend,
   input  logic [WW-1:0]            divisor,
   output logic                     busy,
   output logic [THR_FRAC_BITS-1:0] quotient
);

   localparam int SW = $clog2(THR_FRAC_BITS + 1);

   logic [WW-1:0]            rem_ff, rem_in, div_ff;
   logic [THR_FRAC_BITS-1:0] q_ff, q_in;
   logic [SW-1:0]            step_ff, step_in;
   logic                     busy_ff, busy_in;
   logic [WW:0]              trial;
   logic                     ge;

   // Restoring division: the dividend is below the divisor, so each step
   // doubles the remainder and yields one fraction bit.
   always_comb begin
      trial   = {rem_ff, 1'b0};
      ge      = trial >= {1'b0, div_ff};
      rem_in  = rem_ff;
      q_in    = q_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      if (start) begin
         rem_in  = dividend;
         q_in    = '0;
         step_in = SW'(THR_FRAC_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = ge ? WW'(trial - {1'b0, div_ff}) : trial[WW-1:0];
         q_in    = {q_ff[THR_FRAC_BITS-2:0], ge};
         step_in = step_ff - SW'(1);
         busy_in = step_ff != SW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
      rem_ff <= rem_in;
      q_ff   <= q_in;
      if (start) begin
         div_ff <= divisor;
      end
   end

   assign busy     = busy_ff;
   assign quotient = q_ff;

endmodule

// ===== rtl/core/atb_dp.sv =====
module atb_dp import atb_pkg::*; #(
   parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  atb_cmd_type  cmd,
   output atb_stat_type st,
   input  atb_req_type  req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output atb_rsp_type  rsp_data
);

   `include "assert_macros.svh"

   localparam int AW = $clog2(MAX_ENTRIES);
   localparam int CW = $clog2(MAX_ENTRIES + 1);
   localparam int WW = WEIGHT_BITS + CW;

   logic [31:0] orig_mem [MAX_ENTRIES];
   logic [WW-1:0] work_mem [MAX_ENTRIES];
   logic [15:0] id_mem [MAX_ENTRIES];
   logic [AW-1:0] bq_mem [MAX_ENTRIES];
   logic [AW-1:0] aq_mem [MAX_ENTRIES];

   logic [CW-1:0] cnt_ff, bc_ff, ac_ff;
   logic [WW-1:0] total_ff, prod_ff, wlo_ff, work_q;
   logic [WW:0]   sum_ff;
   logic [AW-1:0] i_ff, bq_q, aq_q;
   logic [31:0]   orig_q;
   logic [15:0]   id_q, idlo_ff, idhi_ff;
   logic          pair_ff, look_ff, hiok_ff;
   logic          rsp_valid_ff;
   atb_rsp_type   rsp_data_ff;

   logic [31:0]   w_in;
   logic          can_store, out_free, fire, i_last;
   logic [AW-1:0] rd_addr;
   logic [WW-1:0] upd;
   logic          push_b, push_a;
   logic [AW-1:0] push_val;
   logic          div_busy, div_start;
   logic [THR_FRAC_BITS-1:0] quot;
   logic [15:0]   alias_id, own_id;

   assign w_in      = req_data.weight & WEIGHT_MASK;
   assign can_store = cnt_ff < CW'(MAX_ENTRIES);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign fire      = cmd.emit && out_free;
   assign i_last    = (CW'(i_ff) + CW'(1)) == cnt_ff;
   assign rd_addr   = cmd.lrd ? bq_q : aq_q;
   assign upd       = (sum_ff >= {1'b0, total_ff}) ? WW'(sum_ff - {1'b0, total_ff}) : '0;
   assign div_start = cmd.hrd && pair_ff;

   always_comb begin
      push_b   = 1'b0;
      push_a   = 1'b0;
      push_val = i_ff;
      if (cmd.cwr) begin
         push_b = prod_ff < total_ff;
         push_a = !(prod_ff < total_ff);
      end else if (fire && pair_ff) begin
         push_val = aq_q;
         push_b   = upd < total_ff;
         push_a   = !(upd < total_ff);
      end
      push_b = push_b && (bc_ff < cnt_ff);
      push_a = push_a && (ac_ff < cnt_ff);
   end

   always_comb begin
      if (pair_ff || hiok_ff) begin
         alias_id = idhi_ff;
      end else if (look_ff) begin
         alias_id = idlo_ff;
      end else begin
         alias_id = '0;
      end
      own_id = pair_ff ? idlo_ff : alias_id;
   end

   atb_div #(.WW(WW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (work_q),
      .divisor  (total_ff),
      .busy     (div_busy),
      .quotient (quot)
   );

   // Stores, each with one write and one registered read.
   always_ff @(posedge clock) begin
      if (cmd.load && can_store) begin
         orig_mem[cnt_ff[AW-1:0]] <= w_in;
         id_mem[cnt_ff[AW-1:0]]   <= req_data.light_index & INDEX_MASK;
      end
      if (cmd.crd || cmd.qrd) begin
         orig_q <= orig_mem[i_ff];
      end
      if (cmd.lrd || cmd.hrd) begin
         id_q   <= id_mem[rd_addr];
         work_q <= work_mem[rd_addr];
      end
      if (cmd.cwr) begin
         work_mem[i_ff] <= prod_ff;
      end else if (fire && pair_ff) begin
         work_mem[aq_q] <= upd;
      end
      if (push_b) begin
         bq_mem[bc_ff[AW-1:0]] <= push_val;
      end
      if (push_a) begin
         aq_mem[ac_ff[AW-1:0]] <= push_val;
      end
      if (cmd.qrd) begin
         bq_q <= bq_mem[i_ff];
         aq_q <= aq_mem[i_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         bc_ff        <= '0;
         ac_ff        <= '0;
         total_ff     <= '0;
         i_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.load) begin
            if (can_store) begin
               cnt_ff   <= cnt_ff + CW'(1);
               total_ff <= total_ff + WW'(w_in);
            end
            if (req_data.last_weight) begin
               i_ff <= '0;
            end
         end
         if (cmd.cwr) begin
            i_ff <= i_last ? '0 : i_ff + AW'(1);
         end
         // The queues empty once the final position of the table has gone.
         if (fire && i_last) begin
            bc_ff <= '0;
            ac_ff <= '0;
         end else begin
            if (push_b) begin
               bc_ff <= bc_ff + CW'(1);
            end
            if (push_a) begin
               ac_ff <= ac_ff + CW'(1);
            end
         end
         if (fire) begin
            rsp_valid_ff <= 1'b1;
            i_ff         <= i_last ? '0 : i_ff + AW'(1);
            if (i_last) begin
               cnt_ff   <= '0;
               total_ff <= '0;
            end
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.cmul) begin
         prod_ff <= WW'(orig_q) * WW'(cnt_ff);
      end
      if (cmd.lrd) begin
         look_ff <= CW'(i_ff) < bc_ff;
         hiok_ff <= CW'(i_ff) < ac_ff;
         pair_ff <= (CW'(i_ff) < bc_ff) && (CW'(i_ff) < ac_ff);
      end
      if (cmd.hrd) begin
         wlo_ff  <= work_q;
         idlo_ff <= id_q;
      end
      if (cmd.cap) begin
         sum_ff  <= {1'b0, wlo_ff} + {1'b0, work_q};
         idhi_ff <= id_q;
      end
      if (fire) begin
         rsp_data_ff.threshold    <= pair_ff ? {1'b0, quot} : THR_ONE;
         rsp_data_ff.alias_index  <= alias_id;
         rsp_data_ff.own_index    <= own_id;
         rsp_data_ff.entry_weight <= orig_q;
         rsp_data_ff.last_entry   <= i_last;
      end
   end

   assign st.i_last   = i_last;
   assign st.pair     = pair_ff;
   assign st.div_busy = div_busy;
   assign st.out_free = out_free;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_data    = rsp_data_ff;

   // Queue fill never passes the number of entries held.
   `ASSERT_ALWAYS(a_queue_bound, clock, reset, (bc_ff <= cnt_ff) && (ac_ff <= cnt_ff))
   // A paired result is never taken before its threshold is finished.
   `ASSERT_ALWAYS(a_div_done, clock, reset, (fire && pair_ff) |-> !div_busy)
   // The divider is never restarted while a division runs.
   `ASSERT_ALWAYS(a_div_idle, clock, reset, div_start |-> !div_busy)
   // Reset empties the store.
   `ASSERT_RESET(a_reset_empty, clock, reset |=> (cnt_ff == '0) && !rsp_valid_ff)

endmodule

// ===== rtl/core/atb_ctrl.sv =====
module atb_ctrl import atb_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_last,
   output logic         req_ready,
   input  atb_stat_type st,
   output atb_cmd_type  cmd
);

   typedef enum logic [9:0] {
      S_LOAD = 10'b0000000001,
      S_CRD  = 10'b0000000010,
      S_CMUL = 10'b0000000100,
      S_CWR  = 10'b0000001000,
      S_QRD  = 10'b0000010000,
      S_LRD  = 10'b0000100000,
      S_HRD  = 10'b0001000000,
      S_CAP  = 10'b0010000000,
      S_DIV  = 10'b0100000000,
      S_EMIT = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_LOAD: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
            if (req_valid && req_last) begin
               state_in = S_CRD;
            end
         end
         S_CRD: begin
            cmd.crd  = 1'b1;
            state_in = S_CMUL;
         end
         S_CMUL: begin
            cmd.cmul = 1'b1;
            state_in = S_CWR;
         end
         S_CWR: begin
            cmd.cwr  = 1'b1;
            state_in = st.i_last ? S_QRD : S_CRD;
         end
         S_QRD: begin
            cmd.qrd  = 1'b1;
            state_in = S_LRD;
         end
         S_LRD: begin
            cmd.lrd  = 1'b1;
            state_in = S_HRD;
         end
         S_HRD: begin
            cmd.hrd  = 1'b1;
            state_in = S_CAP;
         end
         S_CAP: begin
            cmd.cap  = 1'b1;
            state_in = S_DIV;
         end
         S_DIV: begin
            if (!st.pair || !st.div_busy) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            cmd.emit = 1'b1;
            if (st.out_free) begin
               state_in = st.i_last ? S_LOAD : S_QRD;
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/core/alias_table_builder_unit.sv =====
// Alias table builder.
// Weights arrive as beats on the req_ channel (valid/ready), one beat per
// cycle while the block is loading; each beat carries a weight, an entry
// identifier and a last flag. Beats beyond the store depth are dropped, but
// a dropped beat with the last flag still starts construction.
// Once the last beat is taken, req_ready stays low while the table is built.
// Classification handles each entry in turn (store read, scaling multiply,
// queue push). Each table position is then emitted without a division when
// it is a lone entry, and waits for its threshold when it pairs a
// below-average with an above-average entry, as that threshold comes from a
// sixteen-step shared divider. Results leave as rsp_ beats from an output
// register, one per position, the final one flagged by last_entry. A stalled
// receiver holds the block in its emit step; nothing is lost. Reset
// (synchronous) empties the store and the queues at once, with no clearing
// pass.
module alias_table_builder_unit import atb_pkg::*; #(
   parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  atb_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output atb_rsp_type rsp_data
);

   // Commands from the sequencer to the datapath, and status back.
   atb_cmd_type  cmd;
   atb_stat_type st;

   atb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_data.last_weight),
      .req_ready (req_ready),
      .st        (st),
      .cmd       (cmd)
   );

   atb_dp #(.MAX_ENTRIES(MAX_ENTRIES)) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .st        (st),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
